FILE: design/vrps_pkg.sv
// Shared constants and codes for the video register port.
package vrps_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned REG_W  = 3;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LINE_W = 9;
	localparam int unsigned VADR_W = 15;
	localparam int unsigned MADR_W = 14;
	localparam int unsigned PAL_DEPTH = 32;
	localparam int unsigned PAL_AW = $clog2(PAL_DEPTH);

	// Dot ticks between a render-enable change and its effect, minus one.
	localparam logic [3:0] TOGGLE_DELAY = 4'd4;

	localparam logic [OP_W-1:0] OP_REG_READ    = 3'd0;
	localparam logic [OP_W-1:0] OP_REG_WRITE   = 3'd1;
	localparam logic [OP_W-1:0] OP_DOT_TICK    = 3'd2;
	localparam logic [OP_W-1:0] OP_MEM_RETURN  = 3'd3;
	localparam logic [OP_W-1:0] OP_STATUS_LOAD = 3'd4;

	localparam logic [REG_W-1:0] REG_CONTROL     = 3'd0;
	localparam logic [REG_W-1:0] REG_MASK        = 3'd1;
	localparam logic [REG_W-1:0] REG_STATUS      = 3'd2;
	localparam logic [REG_W-1:0] REG_SPRITE_ADDR = 3'd3;
	localparam logic [REG_W-1:0] REG_SPRITE_DATA = 3'd4;
	localparam logic [REG_W-1:0] REG_SCROLL      = 3'd5;
	localparam logic [REG_W-1:0] REG_ADDRESS     = 3'd6;
	localparam logic [REG_W-1:0] REG_DATA        = 3'd7;

	localparam logic [MADR_W-1:0] PALETTE_BASE   = 14'h3F00;
	localparam logic [MADR_W-1:0] PALETTE_MIRROR = 14'h1000;
	localparam logic [LINE_W-1:0] VISIBLE_LINES  = 9'd240;
	localparam logic [LINE_W-1:0] PRERENDER_LINE = 9'd261;

endpackage

FILE: design/vrps_if.sv
// Handshake channels for the register port: request beats in, result beats out.
interface vrps_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [2:0] reg_address;
	logic [7:0] data;
	logic [8:0] scanline;

	modport source (output valid, output op, output reg_address, output data,
		output scanline, input ready);
	modport sink (input valid, input op, input reg_address, input data,
		input scanline, output ready);
endinterface

interface vrps_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        read_valid;
	logic        mem_request;
	logic        mem_write;
	logic [13:0] mem_address;
	logic [7:0]  mem_wdata;

	modport source (output valid, output read_data, output read_valid,
		output mem_request, output mem_write, output mem_address,
		output mem_wdata, input ready);
	modport sink (input valid, input read_data, input read_valid,
		input mem_request, input mem_write, input mem_address,
		input mem_wdata, output ready);
endinterface

FILE: design/video_register_port_scroll_address.sv
// CPU register port of a tile video unit with the scroll/address register pair.
// Every request beat (register read, register write, dot tick, memory read
// return or status load) produces exactly one result beat. A beat is taken
// into an input register; when the result register is empty or being taken,
// its effect on the registers and palette RAM is applied and its result
// captured in the result register. One beat can be accepted every clock while
// results are taken; the result register lets a new beat enter while the
// previous result waits. Data-port accesses at or above 0x3F00 hit the
// internal 32-byte palette RAM; everything else leaves as a video-memory
// request on the result beat. Mask writes that switch rendering on or off
// take effect on the fifth dot tick after the write.
module video_register_port_scroll_address
	import vrps_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	vrps_in_if.sink         request,
	vrps_out_if.source      result
);

	// Input register.
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [REG_W-1:0]  reg_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [LINE_W-1:0] line_s1;

	// Architectural state.
	logic [BYTE_W-1:0] control_q, mask_q, status_q, sprite_data_q, read_buffer_q;
	logic [VADR_W-1:0] temp_q, cur_q;
	logic              second_write_q;
	logic              toggle_pending_q;
	logic [3:0]        countdown_q;
	logic [1:0]        pending_bits_q;
	logic [BYTE_W-1:0] palette_q [PAL_DEPTH];

	// Result register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] read_data_q, mem_wdata_q;
	logic              read_valid_q, mem_request_q, mem_write_q;
	logic [MADR_W-1:0] mem_address_q;

	// Next values.
	logic [BYTE_W-1:0] control_d, mask_d, status_d, sprite_data_d, read_buffer_d;
	logic [VADR_W-1:0] temp_d, cur_d;
	logic              second_write_d, toggle_pending_d;
	logic [3:0]        countdown_d;
	logic [1:0]        pending_bits_d;
	logic              pal_we;
	logic [BYTE_W-1:0] read_data_d, mem_wdata_d;
	logic              read_valid_d, mem_request_d, mem_write_d;
	logic [MADR_W-1:0] mem_address_d;

	logic              adv;
	logic              render_on, render_line;
	logic [MADR_W-1:0] vaddr;
	logic [PAL_AW-1:0] pal_idx;
	logic              is_palette;
	logic [VADR_W-1:0] cur_step;

	assign adv = valid_s1 && (!out_valid_q || result.ready);
	assign request.ready = !valid_s1 || adv;

	assign render_on = (mask_q[4:3] != 2'b00);
	assign render_line = (line_s1 < VISIBLE_LINES) || (line_s1 == PRERENDER_LINE);
	assign vaddr = cur_q[MADR_W-1:0];
	assign pal_idx = vaddr[PAL_AW-1:0];
	assign is_palette = (vaddr >= PALETTE_BASE);

	// Address step after a data-port access: coarse X then fine Y while
	// rendering, a flat 1 or 32 otherwise.
	always_comb begin
		logic [VADR_W-1:0] v1;
		logic [4:0]        y;
		v1 = cur_q;
		y = 5'd0;
		cur_step = cur_q;
		if (render_on && render_line) begin
			if (cur_q[4:0] == 5'd31) begin
				v1 = {cur_q[14:11], ~cur_q[10], cur_q[9:5], 5'd0};
			end else begin
				v1 = {cur_q[14:5], cur_q[4:0] + 5'd1};
			end
			if (v1[14:12] != 3'b111) begin
				cur_step = {v1[14:12] + 3'd1, v1[11:0]};
			end else begin
				y = v1[9:5];
				cur_step = {3'b000, v1[11:0]};
				if (y == 5'd29) begin
					cur_step[11] = ~v1[11];
					cur_step[9:5] = 5'd0;
				end else if (y == 5'd31) begin
					cur_step[9:5] = 5'd0;
				end else begin
					cur_step[9:5] = y + 5'd1;
				end
			end
		end else begin
			cur_step = cur_q + (control_q[2] ? VADR_W'(32) : VADR_W'(1));
		end
	end

	always_comb begin
		control_d        = control_q;
		mask_d           = mask_q;
		status_d         = status_q;
		sprite_data_d    = sprite_data_q;
		read_buffer_d    = read_buffer_q;
		temp_d           = temp_q;
		cur_d            = cur_q;
		second_write_d   = second_write_q;
		toggle_pending_d = toggle_pending_q;
		countdown_d      = countdown_q;
		pending_bits_d   = pending_bits_q;
		pal_we           = 1'b0;
		read_data_d      = '0;
		read_valid_d     = 1'b0;
		mem_request_d    = 1'b0;
		mem_write_d      = 1'b0;
		mem_address_d    = '0;
		mem_wdata_d      = '0;

		case (op_s1)
			OP_REG_READ: begin
				read_valid_d = 1'b1;
				case (reg_s1)
					REG_STATUS: begin
						read_data_d = status_q;
						status_d[7] = 1'b0;
						second_write_d = 1'b0;
					end
					REG_SPRITE_DATA: read_data_d = sprite_data_q;
					REG_DATA: begin
						mem_request_d = 1'b1;
						if (is_palette) begin
							read_data_d = palette_q[pal_idx];
							mem_address_d = vaddr - PALETTE_MIRROR;
						end else begin
							read_data_d = read_buffer_q;
							mem_address_d = vaddr;
						end
						cur_d = cur_step;
					end
					default: ;
				endcase
			end
			OP_REG_WRITE: begin
				case (reg_s1)
					REG_CONTROL: begin
						control_d = data_s1;
						temp_d[11:10] = data_s1[1:0];
						if (!render_on) begin
							cur_d = {temp_q[14:12], data_s1[1:0], temp_q[9:0]};
						end
					end
					REG_MASK: begin
						// A change of the render-enable bits is held back and
						// applied by the dot-tick countdown.
						if (render_on != (data_s1[4:3] != 2'b00)) begin
							toggle_pending_d = 1'b1;
							countdown_d = TOGGLE_DELAY;
							pending_bits_d = data_s1[4:3];
							mask_d = {data_s1[7:5], 2'b00, data_s1[2:0]};
						end else begin
							mask_d = data_s1;
						end
					end
					REG_SPRITE_DATA: sprite_data_d = data_s1;
					REG_SCROLL: begin
						if (second_write_q) begin
							temp_d[14:12] = data_s1[2:0];
							temp_d[9:5] = data_s1[7:3];
						end else begin
							temp_d[4:0] = data_s1[7:3];
						end
						second_write_d = ~second_write_q;
					end
					REG_ADDRESS: begin
						if (second_write_q) begin
							temp_d = {temp_q[14:8], data_s1};
							if (!render_on) begin
								cur_d = {temp_q[14:8], data_s1};
							end
						end else begin
							temp_d = {1'b0, data_s1[5:0], temp_q[7:0]};
						end
						second_write_d = ~second_write_q;
					end
					REG_DATA: begin
						if (is_palette) begin
							pal_we = 1'b1;
						end else begin
							mem_request_d = 1'b1;
							mem_write_d = 1'b1;
							mem_address_d = vaddr;
							mem_wdata_d = data_s1;
						end
						cur_d = cur_step;
					end
					default: ;
				endcase
			end
			OP_DOT_TICK: begin
				if (toggle_pending_q) begin
					if (countdown_q == 4'd0) begin
						toggle_pending_d = 1'b0;
						mask_d[4:3] = pending_bits_q;
						pending_bits_d = 2'b00;
					end else begin
						countdown_d = countdown_q - 4'd1;
					end
				end
			end
			OP_MEM_RETURN: read_buffer_d = data_s1;
			OP_STATUS_LOAD: status_d = data_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.valid && request.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			op_s1   <= request.op;
			reg_s1  <= request.reg_address;
			data_s1 <= request.data;
			line_s1 <= request.scanline;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q        <= '0;
			mask_q           <= '0;
			status_q         <= '0;
			sprite_data_q    <= '0;
			read_buffer_q    <= '0;
			temp_q           <= '0;
			cur_q            <= '0;
			second_write_q   <= 1'b0;
			toggle_pending_q <= 1'b0;
			countdown_q      <= '0;
			pending_bits_q   <= '0;
			for (int i = 0; i < PAL_DEPTH; i++) begin
				palette_q[i] <= '0;
			end
		end else if (adv) begin
			control_q        <= control_d;
			mask_q           <= mask_d;
			status_q         <= status_d;
			sprite_data_q    <= sprite_data_d;
			read_buffer_q    <= read_buffer_d;
			temp_q           <= temp_d;
			cur_q            <= cur_d;
			second_write_q   <= second_write_d;
			toggle_pending_q <= toggle_pending_d;
			countdown_q      <= countdown_d;
			pending_bits_q   <= pending_bits_d;
			if (pal_we) begin
				palette_q[pal_idx] <= data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q   <= read_data_d;
			read_valid_q  <= read_valid_d;
			mem_request_q <= mem_request_d;
			mem_write_q   <= mem_write_d;
			mem_address_q <= mem_address_d;
			mem_wdata_q   <= mem_wdata_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.read_data   = read_data_q;
	assign result.read_valid  = read_valid_q;
	assign result.mem_request = mem_request_q;
	assign result.mem_write   = mem_write_q;
	assign result.mem_address = mem_address_q;
	assign result.mem_wdata   = mem_wdata_q;

endmodule

FILE: design/vrps_checker.sv
// Port-level checks on the register port's result beats, bound to the top level.
module vrps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [7:0]  read_data,
	input logic        read_valid,
	input logic        mem_request,
	input logic        mem_write,
	input logic [13:0] mem_address,
	input logic [7:0]  mem_wdata
);

	// A stalled result beat keeps its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(read_data) && $stable(read_valid)
			&& $stable(mem_request) && $stable(mem_write)
			&& $stable(mem_address) && $stable(mem_wdata))
		else $error("result beat changed while stalled");

	// A write access is always a memory request, and a register read never writes.
	a_write_is_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid && mem_write |-> mem_request && !read_valid)
		else $error("memory write without request or during a register read");

	// Read data is zero unless the beat carries a register read.
	a_read_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !read_valid |-> read_data == 8'd0)
		else $error("read data set on a beat without a register read");

	// Without an access the address is zero; write data only on a write.
	a_idle_access_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (mem_request || mem_address == 14'd0)
			&& (mem_write || mem_wdata == 8'd0))
		else $error("access fields set without a matching access");

endmodule

bind video_register_port_scroll_address vrps_checker u_vrps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.read_data   (result.read_data),
	.read_valid  (result.read_valid),
	.mem_request (result.mem_request),
	.mem_write   (result.mem_write),
	.mem_address (result.mem_address),
	.mem_wdata   (result.mem_wdata)
);

FILE: tb/sv/reg_port_checker.sv
`timescale 1ns / 100ps
// Checker for the video register port: predicts every result beat and compares it with the block.
module reg_port_checker
	import vrps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	vrps_in_if          request,
	vrps_out_if         result,
	output int unsigned errors,
	output int unsigned pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              read_valid;
		logic              mem_request;
		logic              mem_write;
		logic [MADR_W-1:0] mem_address;
		logic [BYTE_W-1:0] mem_wdata;
	} port_result_t;

	localparam logic [BYTE_W-1:0] RENDER_MASK = 8'h18;
	localparam int unsigned SHOWN_FAULTS = 10;

	logic [BYTE_W-1:0] ctrl_q, mask_q, status_q, oam_addr_q, oam_data_q, rd_buffer;
	logic [VADR_W-1:0] t_addr, v_addr;
	logic [2:0]        fine_x_q;
	logic              w_q;
	logic [BYTE_W-1:0] palette [PAL_DEPTH];
	logic              toggle_armed;
	logic [3:0]        toggle_count;
	logic [1:0]        toggle_bits;

	port_result_t expected_beats [$];
	port_result_t oldest;
	int unsigned  fault_count;

	function automatic logic render_enabled();
		return (mask_q & RENDER_MASK) != '0;
	endfunction

	// Address step after a data-port access: coarse X then fine Y while rendering.
	function automatic logic [VADR_W-1:0] advance_vaddr(input logic [LINE_W-1:0] line);
		logic [VADR_W-1:0] v;
		logic [4:0]        y;
		v = v_addr;
		if (render_enabled() && (line < VISIBLE_LINES || line == PRERENDER_LINE)) begin
			if (v[4:0] == 5'd31) begin
				v[4:0] = '0;
				v[10]  = ~v[10];
			end else begin
				v[4:0] = v[4:0] + 5'd1;
			end
			if (v[14:12] != 3'd7) begin
				v[14:12] = v[14:12] + 3'd1;
			end else begin
				y        = v[9:5];
				v[14:12] = '0;
				if (y == 5'd29) begin
					y     = '0;
					v[11] = ~v[11];
				end else if (y == 5'd31) begin
					y = '0;
				end else begin
					y = y + 5'd1;
				end
				v[9:5] = y;
			end
		end else begin
			v = v + (ctrl_q[2] ? 15'd32 : 15'd1);
		end
		return v;
	endfunction

	function automatic port_result_t predict_access(input logic [OP_W-1:0] op,
			input logic [REG_W-1:0] ra, input logic [BYTE_W-1:0] d,
			input logic [LINE_W-1:0] line);
		port_result_t      r;
		logic [MADR_W-1:0] a;
		logic [BYTE_W-1:0] nb;
		r = '0;
		a = v_addr[MADR_W-1:0];
		case (op)
			OP_REG_READ: begin
				r.read_valid = 1'b1;
				case (ra)
					REG_STATUS: begin
						r.read_data = status_q;
						status_q[7] = 1'b0;
						w_q         = 1'b0;
					end
					REG_SPRITE_DATA: r.read_data = oam_data_q;
					REG_DATA: begin
						r.mem_request = 1'b1;
						if (a >= PALETTE_BASE) begin
							r.read_data   = palette[a[PAL_AW-1:0]];
							r.mem_address = a - PALETTE_MIRROR;
						end else begin
							r.read_data   = rd_buffer;
							r.mem_address = a;
						end
						v_addr = advance_vaddr(line);
					end
					default: ;
				endcase
			end
			OP_REG_WRITE: begin
				case (ra)
					REG_CONTROL: begin
						ctrl_q        = d;
						t_addr[11:10] = d[1:0];
						if (!render_enabled()) v_addr = t_addr;
					end
					REG_MASK: begin
						nb = d & RENDER_MASK;
						// Switching rendering on or off is deferred to a later dot tick.
						if (render_enabled() != (nb != '0)) begin
							toggle_armed = 1'b1;
							toggle_count = TOGGLE_DELAY;
							toggle_bits  = nb[4:3];
							mask_q       = d & ~RENDER_MASK;
						end else begin
							mask_q = d;
						end
					end
					REG_SPRITE_ADDR: oam_addr_q = d;
					REG_SPRITE_DATA: oam_data_q = d;
					REG_SCROLL: begin
						if (w_q) begin
							t_addr[14:12] = d[2:0];
							t_addr[9:5]   = d[7:3];
						end else begin
							t_addr[4:0] = d[7:3];
							fine_x_q    = d[2:0];
						end
						w_q = ~w_q;
					end
					REG_ADDRESS: begin
						if (w_q) begin
							t_addr = {t_addr[14:8], d};
							if (!render_enabled()) v_addr = t_addr;
						end else begin
							t_addr = {1'b0, d[5:0], t_addr[7:0]};
						end
						w_q = ~w_q;
					end
					REG_DATA: begin
						if (a >= PALETTE_BASE) begin
							palette[a[PAL_AW-1:0]] = d;
						end else begin
							r.mem_request = 1'b1;
							r.mem_write   = 1'b1;
							r.mem_address = a;
							r.mem_wdata   = d;
						end
						v_addr = advance_vaddr(line);
					end
					default: ;
				endcase
			end
			OP_DOT_TICK: begin
				if (toggle_armed) begin
					if (toggle_count == '0) begin
						toggle_armed = 1'b0;
						mask_q[4:3]  = toggle_bits;
						toggle_bits  = '0;
					end else begin
						toggle_count = toggle_count - 4'd1;
					end
				end
			end
			OP_MEM_RETURN: rd_buffer = d;
			OP_STATUS_LOAD: status_q = d;
			default: ;
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			if (fault_count < SHOWN_FAULTS)
				$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       = '0;
			mask_q       = '0;
			status_q     = '0;
			oam_addr_q   = '0;
			oam_data_q   = '0;
			rd_buffer    = '0;
			t_addr       = '0;
			v_addr       = '0;
			fine_x_q     = '0;
			w_q          = 1'b0;
			toggle_armed = 1'b0;
			toggle_count = '0;
			toggle_bits  = '0;
			for (int i = 0; i < PAL_DEPTH; i++) palette[i] = '0;
			expected_beats.delete();
			fault_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// Retire the result first: a request beat taken on this edge cannot be its source.
			if (result.valid && result.ready) begin
				if (expected_beats.size() == 0) begin
					if (fault_count < SHOWN_FAULTS)
						$display("%0t: result beat with nothing predicted (read_data 0x%0h)",
							$time, result.read_data);
					fault_count++;
				end else begin
					oldest = expected_beats.pop_front();
					compare_field("read_data", 32'(oldest.read_data), 32'(result.read_data));
					compare_field("read_valid", 32'(oldest.read_valid),
						32'(result.read_valid));
					compare_field("mem_request", 32'(oldest.mem_request),
						32'(result.mem_request));
					compare_field("mem_write", 32'(oldest.mem_write), 32'(result.mem_write));
					compare_field("mem_address", 32'(oldest.mem_address),
						32'(result.mem_address));
					compare_field("mem_wdata", 32'(oldest.mem_wdata), 32'(result.mem_wdata));
				end
			end
			if (request.valid && request.ready)
				expected_beats.push_back(predict_access(request.op, request.reg_address,
					request.data, request.scanline));
			errors  <= fault_count;
			pending <= expected_beats.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the video register port: request stimulus, result pacing and verdict.
module tb
	import vrps_pkg::*;
();

	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_BEATS = 450;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vrps_in_if  request ();
	vrps_out_if result ();

	int unsigned errors;
	int unsigned pending;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned beats_sent = 0;
	int unsigned quiet_cycles = 0;

	always #1 clk = ~clk;

	video_register_port_scroll_address uut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	reg_port_checker port_check (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result),
		.errors (errors),
		.pending(pending)
	);

	// Result side: random stalls, and a long hold-off whenever one is asked for.
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				result.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (request.valid && request.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT) begin
			$display("video_register_port_scroll_address regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(input logic [OP_W-1:0] op, input logic [REG_W-1:0] ra,
			input logic [BYTE_W-1:0] d, input logic [LINE_W-1:0] line);
		while ($urandom_range(99) < send_idle_pct) begin
			request.valid <= 1'b0;
			@(posedge clk);
		end
		request.valid       <= 1'b1;
		request.op          <= op;
		request.reg_address <= ra;
		request.data        <= d;
		request.scanline    <= line;
		@(posedge clk);
		while (!request.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic wait_drained();
		request.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [LINE_W-1:0] pick_line();
		case ($urandom_range(9))
			0, 1, 2, 3: return LINE_W'($urandom_range(239));
			4, 5:       return PRERENDER_LINE;
			6, 7:       return LINE_W'($urandom_range(260, 240));
			default:    return LINE_W'($urandom_range(511));
		endcase
	endfunction

	// One short access sequence; most of them are well formed so that scroll,
	// address and render-toggle logic get exercised past their first states.
	task automatic run_scenario();
		logic [BYTE_W-1:0] hi;
		int unsigned       n;
		case ($urandom_range(15))
			0, 1, 2: begin
				if ($urandom_range(3) != 0) send_beat(OP_REG_READ, REG_STATUS, 8'($urandom), pick_line());
				hi = 8'($urandom);
				if ($urandom_range(2) == 0) hi[5:0] = 6'h3F;
				send_beat(OP_REG_WRITE, REG_ADDRESS, hi, pick_line());
				send_beat(OP_REG_WRITE, REG_ADDRESS, 8'($urandom), pick_line());
				n = $urandom_range(6, 1);
				repeat (n) begin
					case ($urandom_range(3))
						0:       send_beat(OP_REG_WRITE, REG_DATA, 8'($urandom), pick_line());
						3:       send_beat(OP_MEM_RETURN, 3'($urandom), 8'($urandom), pick_line());
						default: send_beat(OP_REG_READ, REG_DATA, 8'($urandom), pick_line());
					endcase
				end
			end
			3, 4: begin
				if ($urandom_range(3) != 0) send_beat(OP_REG_READ, REG_STATUS, 8'($urandom), pick_line());
				send_beat(OP_REG_WRITE, REG_SCROLL, 8'($urandom), pick_line());
				send_beat(OP_REG_WRITE, REG_SCROLL, 8'($urandom), pick_line());
			end
			5, 6: begin
				send_beat(OP_REG_WRITE, REG_MASK, 8'($urandom), pick_line());
				n = $urandom_range(8);
				repeat (n) send_beat(OP_DOT_TICK, 3'($urandom), 8'($urandom), pick_line());
			end
			7: send_beat(OP_REG_WRITE, REG_CONTROL, 8'($urandom), pick_line());
			8: begin
				send_beat(OP_STATUS_LOAD, 3'($urandom), 8'($urandom), pick_line());
				send_beat(OP_REG_READ, REG_STATUS, 8'($urandom), pick_line());
			end
			9: begin
				send_beat(OP_REG_WRITE, REG_SPRITE_ADDR, 8'($urandom), pick_line());
				send_beat(OP_REG_WRITE, REG_SPRITE_DATA, 8'($urandom), pick_line());
				send_beat(OP_REG_READ, REG_SPRITE_DATA, 8'($urandom), pick_line());
			end
			10, 11: begin
				n = $urandom_range(6, 1);
				repeat (n) send_beat(OP_DOT_TICK, 3'($urandom), 8'($urandom), pick_line());
			end
			12: send_beat(OP_MEM_RETURN, 3'($urandom), 8'($urandom), pick_line());
			13: send_beat(OP_REG_READ, 3'($urandom), 8'($urandom), pick_line());
			default: send_beat(3'($urandom), 3'($urandom), 8'($urandom), LINE_W'($urandom));
		endcase
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		target = beats_sent + count;
		while (beats_sent < target) run_scenario();
	endtask

	initial begin
		request.valid       <= 1'b0;
		request.op          <= OP_REG_READ;
		request.reg_address <= REG_CONTROL;
		request.data        <= '0;
		request.scanline    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Status read clears bit 7 and the write toggle.
		send_beat(OP_REG_READ, REG_STATUS, 8'h00, 9'd0);
		send_beat(OP_STATUS_LOAD, REG_CONTROL, 8'hFF, 9'd0);
		send_beat(OP_REG_READ, REG_STATUS, 8'h00, 9'd239);
		send_beat(OP_REG_READ, REG_STATUS, 8'h00, VISIBLE_LINES);
		send_beat(OP_REG_WRITE, REG_STATUS, 8'hAA, 9'd0);
		send_beat(OP_REG_READ, REG_CONTROL, 8'h00, 9'd0);
		send_beat(OP_REG_WRITE, REG_SPRITE_DATA, 8'hFF, 9'd0);
		send_beat(OP_REG_READ, REG_SPRITE_DATA, 8'h00, 9'd0);
		// Palette writes at the bottom and top of the palette range.
		send_beat(OP_REG_WRITE, REG_ADDRESS, 8'hFF, 9'd0);
		send_beat(OP_REG_WRITE, REG_ADDRESS, 8'h00, 9'd0);
		send_beat(OP_REG_WRITE, REG_DATA, 8'h5A, 9'd0);
		send_beat(OP_REG_WRITE, REG_ADDRESS, 8'h3F, 9'd0);
		send_beat(OP_REG_WRITE, REG_ADDRESS, 8'hFF, 9'd0);
		send_beat(OP_REG_WRITE, REG_DATA, 8'hA5, 9'd0);
		// The address has crossed into the 15-bit top; buffered read comes next.
		send_beat(OP_REG_READ, REG_DATA, 8'h00, 9'd0);
		send_beat(OP_MEM_RETURN, REG_CONTROL, 8'hC3, 9'd0);
		send_beat(OP_REG_WRITE, REG_CONTROL, 8'hFF, 9'd0);
		send_beat(OP_REG_READ, REG_DATA, 8'h00, 9'd0);
		send_beat(OP_REG_READ, REG_DATA, 8'h00, 9'd0);
		send_beat(OP_REG_WRITE, REG_SCROLL, 8'hFF, 9'd0);
		send_beat(OP_REG_WRITE, REG_SCROLL, 8'hFF, 9'd0);
		send_beat(OP_UNUSED, REG_DATA, 8'hFF, 9'h1FF);
		// Render enable, then a same-state mask write while the toggle is pending.
		send_beat(OP_REG_WRITE, REG_MASK, 8'hFF, 9'd0);
		send_beat(OP_REG_WRITE, REG_MASK, 8'h00, 9'd0);
		repeat (5) send_beat(OP_DOT_TICK, REG_CONTROL, 8'h00, 9'd0);
		send_beat(OP_REG_READ, REG_DATA, 8'h00, PRERENDER_LINE);
		send_beat(OP_REG_WRITE, REG_DATA, 8'h3C, 9'd100);
		wait_drained();

		// Back-pressure: the result side holds off while requests keep coming.
		hold_asks++;
		run_random(60);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			run_random(PHASE_BEATS);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("video_register_port_scroll_address regression: pass");
		end else begin
			$display("video_register_port_scroll_address regression: fail");
		end
		$finish;
	end

endmodule

FILE: video_register_port_scroll_address.f
design/vrps_pkg.sv
design/vrps_if.sv
design/video_register_port_scroll_address.sv
design/vrps_checker.sv
tb/sv/reg_port_checker.sv
tb/sv/tb.sv
